@@ hw/rtl/imuonc_pkg.sv @@
// Shared types and constants for the IMU offset nulling calibrator.
`default_nettype none
package imuonc_pkg;

	localparam int NUM_AXES = 6;
	localparam int NUM_GYRO = 3;

	typedef logic signed [15:0] sample_t;
	typedef logic [15:0]        word_t;
	typedef logic [14:0]        limit_t;

	// per-axis status handed from an axis slice to the top level
	typedef struct packed {
		logic  locked_q;   // current sticky lock
		logic  lock_next;  // lock after the sample being processed
		word_t sum;        // factory offset plus next adjustment, wrapped
	} axis_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/imuonc_axis.sv @@
// One axis slice: adjustment counter, sticky lock and offset sum.
`default_nettype none
module imuonc_axis
	import imuonc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire sample_t    reading,
	input  wire limit_t     limit,
	input  wire sample_t    factory,
	output axis_stat_t      stat
);

	word_t adj_q;
	word_t adj_next;
	logic  locked_q;
	word_t mag;
	logic  in_limit;

	// 16-bit negate: -32768 stays 0x8000, i.e. 32768, and never locks
	assign mag      = reading[15] ? (word_t'(~reading) + 16'd1) : word_t'(reading);
	assign in_limit = (mag <= {1'b0, limit});

	always_comb begin
		adj_next = adj_q;
		if (step && !locked_q) begin
			if (reading < 0) begin
				adj_next = adj_q + 16'd1;
			end else if (reading != 0) begin
				adj_next = adj_q - 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_q    <= '0;
			locked_q <= 1'b0;
		end else if (step) begin
			adj_q    <= adj_next;
			locked_q <= locked_q | in_limit;
		end
	end

	assign stat.locked_q  = locked_q;
	assign stat.lock_next = locked_q | (step & in_limit);
	assign stat.sum       = word_t'(factory) + adj_next;

endmodule
`default_nettype wire

@@ hw/rtl/imu_offset_nulling_calibrator_core.sv @@
// Top level of the IMU offset nulling calibrator: input stage, axis slices, result register.
// Path: input register, then result register; out_valid rises when the result register is loaded.
// Throughput: one sample per cycle while out_stall is low; the per-axis step and lock compare are combinational.
// The input register lets a new transaction in while a finished result waits on out_stall.
// Reset (arst_n low, async): adjustments and locks cleared, first sample is discarded,
// factory offsets 0, both lock limits 1, no transaction held in either register.
`default_nettype none
module imu_offset_nulling_calibrator_core
	import imuonc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_write_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// sample input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire sample_t     gyro_x,
	input  wire sample_t     gyro_y,
	input  wire sample_t     gyro_z,
	input  wire sample_t     accel_x,
	input  wire sample_t     accel_y,
	input  wire sample_t     accel_z,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             write_valid,
	output logic             done_res,
	output word_t            gyro_word_x,
	output word_t            gyro_word_y,
	output word_t            gyro_word_z,
	output word_t            accel_word_x,
	output word_t            accel_word_y,
	output word_t            accel_word_z
);

	typedef enum logic [2:0] {
		CFG_FAC_GX  = 3'd0,
		CFG_FAC_GY  = 3'd1,
		CFG_FAC_GZ  = 3'd2,
		CFG_FAC_AX  = 3'd3,
		CFG_FAC_AY  = 3'd4,
		CFG_FAC_AZ  = 3'd5,
		CFG_G_LIMIT = 3'd6,
		CFG_A_LIMIT = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_DISCARD,
		PH_RUN,
		PH_DONE
	} phase_t;

	// ---------------- configuration registers ----------------
	sample_t factory_q [NUM_AXES];
	limit_t  gyro_limit_q;
	limit_t  accel_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				factory_q[i] <= '0;
			end
			gyro_limit_q  <= 15'd1;
			accel_limit_q <= 15'd1;
		end else if (cfg_write_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FAC_GX:  factory_q[0]  <= cfg_data;
				CFG_FAC_GY:  factory_q[1]  <= cfg_data;
				CFG_FAC_GZ:  factory_q[2]  <= cfg_data;
				CFG_FAC_AX:  factory_q[3]  <= cfg_data;
				CFG_FAC_AY:  factory_q[4]  <= cfg_data;
				CFG_FAC_AZ:  factory_q[5]  <= cfg_data;
				CFG_G_LIMIT: gyro_limit_q  <= cfg_data[14:0];
				CFG_A_LIMIT: accel_limit_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// ---------------- input register (stage 1) ----------------
	logic    in_valid_s1;
	sample_t sample_s1 [NUM_AXES];
	logic    move;   // stage 1 transaction is processed into the result register
	logic    in_take;

	assign move     = in_valid_s1 && (!out_valid || !out_stall);
	assign in_stall = in_valid_s1 && !move;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_take) begin
			in_valid_s1 <= 1'b1;
		end else if (move) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1[0] <= gyro_x;
			sample_s1[1] <= gyro_y;
			sample_s1[2] <= gyro_z;
			sample_s1[3] <= accel_x;
			sample_s1[4] <= accel_y;
			sample_s1[5] <= accel_z;
		end
	end

	// ---------------- axis slices ----------------
	phase_t          phase_q;
	logic            step;
	axis_stat_t      stat [NUM_AXES];
	logic [NUM_AXES-1:0] locked_now;
	logic [NUM_AXES-1:0] locked_next;

	// adjustments only move on samples that arrive while calibrating
	assign step = move && (phase_q == PH_RUN);

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		imuonc_axis u_axis (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (step),
			.reading (sample_s1[a]),
			.limit   ((a < NUM_GYRO) ? gyro_limit_q : accel_limit_q),
			.factory (factory_q[a]),
			.stat    (stat[a])
		);
		assign locked_now[a]  = stat[a].locked_q;
		assign locked_next[a] = stat[a].lock_next;
	end

	// ---------------- phase and result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DISCARD;
			out_valid   <= 1'b0;
			write_valid <= 1'b0;
			done_res    <= 1'b0;
		end else begin
			if (move) begin
				out_valid <= 1'b1;
				case (phase_q)
					PH_DISCARD: begin
						phase_q     <= PH_RUN;
						write_valid <= 1'b0;
						done_res    <= 1'b0;
					end
					PH_RUN: begin
						if (&locked_next) begin
							// the completing sample: adjustments land, no write
							phase_q     <= PH_DONE;
							write_valid <= 1'b0;
							done_res    <= 1'b1;
						end else begin
							write_valid <= 1'b1;
							done_res    <= 1'b0;
						end
					end
					default: begin
						write_valid <= 1'b0;
						done_res    <= 1'b1;
					end
				endcase
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	logic emit_words;
	assign emit_words = (phase_q == PH_RUN) && !(&locked_next);

	// words are zero whenever no register write is requested
	always_ff @(posedge clk) begin
		if (move) begin
			if (emit_words) begin
				gyro_word_x  <= stat[0].sum;
				gyro_word_y  <= stat[1].sum;
				gyro_word_z  <= stat[2].sum;
				accel_word_x <= {stat[3].sum[14:0], 1'b0};
				accel_word_y <= {stat[4].sum[14:0], 1'b0};
				accel_word_z <= {stat[5].sum[14:0], 1'b0};
			end else begin
				gyro_word_x  <= '0;
				gyro_word_y  <= '0;
				gyro_word_z  <= '0;
				accel_word_x <= '0;
				accel_word_y <= '0;
				accel_word_z <= '0;
			end
		end
	end

	// ---------------- assertions ----------------
	a_wv_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(write_valid && done_res))
		else $error("write_valid and done_res both set");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("left done phase without reset");

	a_wv_not_all_locked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_valid) |-> !(&locked_now))
		else $error("write requested with all axes locked");

	a_discard_no_locks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DISCARD |-> locked_now == '0)
		else $error("axis locked before first sample was discarded");

	a_step_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> (in_valid_s1 && (phase_q == PH_RUN)))
		else $error("axis step without a held sample");

endmodule
`default_nettype wire

@@ bench/imu_offset_nulling_calibrator_checker.sv @@
// Register index names for the bench, and the checker that predicts and compares offset writes.
`timescale 1ns / 1ps
package imuonc_bench_pkg;

	typedef enum logic [2:0] {
		REG_FACTORY_GX,
		REG_FACTORY_GY,
		REG_FACTORY_GZ,
		REG_FACTORY_AX,
		REG_FACTORY_AY,
		REG_FACTORY_AZ,
		REG_GYRO_LIMIT,
		REG_ACCEL_LIMIT
	} cfg_reg_e;

endpackage

module imu_offset_nulling_calibrator_checker
	import imuonc_pkg::*;
	import imuonc_bench_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  sample_t     gyro_x,
	input  sample_t     gyro_y,
	input  sample_t     gyro_z,
	input  sample_t     accel_x,
	input  sample_t     accel_y,
	input  sample_t     accel_z,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        write_valid,
	input  logic        done_res,
	input  word_t       gyro_word_x,
	input  word_t       gyro_word_y,
	input  word_t       gyro_word_z,
	input  word_t       accel_word_x,
	input  word_t       accel_word_y,
	input  word_t       accel_word_z,
	output int          fail_count,
	output int          outstanding,
	output int          writes_seen,
	output int          done_seen
);

	localparam int MAX_REPORTS = 10;
	localparam string AXIS_NAME [NUM_AXES] = '{"gyro_word_x", "gyro_word_y", "gyro_word_z",
		"accel_word_x", "accel_word_y", "accel_word_z"};

	typedef enum logic [1:0] {CAL_DISCARD, CAL_RUN, CAL_DONE} cal_phase_e;

	typedef struct packed {
		logic                  wr;
		logic                  done;
		word_t [NUM_AXES-1:0]  words;
	} offset_write_t;

	word_t               factory_off [NUM_AXES];
	limit_t              gyro_limit;
	limit_t              accel_limit;
	word_t               adjust [NUM_AXES];
	logic [NUM_AXES-1:0] locked;
	cal_phase_e          cal_phase;
	offset_write_t       offset_words_due [$];
	int                  result_num;

	// one sample through the calibration: step, lock, then the register words
	task automatic calibrate_sample(input sample_t rd [NUM_AXES], output offset_write_t res);
		int    mag;
		word_t sum;
		res = '0;
		case (cal_phase)
			CAL_DISCARD: cal_phase = CAL_RUN;
			CAL_DONE:    res.done = 1'b1;
			default: begin
				for (int a = 0; a < NUM_AXES; a++) begin
					mag = (rd[a] < 0) ? -int'(rd[a]) : int'(rd[a]);
					if (!locked[a]) begin
						if (rd[a] < 0)
							adjust[a] = adjust[a] + 16'd1;
						else if (rd[a] > 0)
							adjust[a] = adjust[a] - 16'd1;
					end
					if (mag <= int'((a < NUM_GYRO) ? gyro_limit : accel_limit))
						locked[a] = 1'b1;
				end
				if (&locked) begin
					cal_phase = CAL_DONE;
					res.done = 1'b1;
				end else begin
					res.wr = 1'b1;
					for (int a = 0; a < NUM_AXES; a++) begin
						sum = factory_off[a] + adjust[a];
						res.words[a] = (a < NUM_GYRO) ? sum : {sum[14:0], 1'b0};
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		sample_t       rd [NUM_AXES];
		offset_write_t want;
		offset_write_t got;
		if (!arst_n) begin
			foreach (factory_off[a]) begin
				factory_off[a] = '0;
				adjust[a] = '0;
			end
			gyro_limit = 15'd1;
			accel_limit = 15'd1;
			locked = '0;
			cal_phase = CAL_DISCARD;
			offset_words_due.delete();
			fail_count = 0;
			outstanding = 0;
			writes_seen = 0;
			done_seen = 0;
			result_num = 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_FACTORY_GX, REG_FACTORY_GY, REG_FACTORY_GZ,
					REG_FACTORY_AX, REG_FACTORY_AY, REG_FACTORY_AZ: begin
						factory_off[cfg_index] = cfg_data;
					end
					REG_GYRO_LIMIT:  gyro_limit = limit_t'(cfg_data);
					REG_ACCEL_LIMIT: accel_limit = limit_t'(cfg_data);
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				rd = '{gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z};
				calibrate_sample(rd, want);
				offset_words_due.push_back(want);
			end

			if (out_valid && !out_stall) begin
				got.wr = write_valid;
				got.done = done_res;
				got.words = {accel_word_z, accel_word_y, accel_word_x,
					gyro_word_z, gyro_word_y, gyro_word_x};
				result_num++;
				if (offset_words_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: result %0d arrived with no sample pending",
							$time, result_num);
				end else begin
					want = offset_words_due.pop_front();
					writes_seen += want.wr;
					done_seen += want.done;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("%0t: result %0d: write_valid exp %b got %b, done_res exp %b got %b",
								$time, result_num, want.wr, got.wr, want.done, got.done);
							for (int a = 0; a < NUM_AXES; a++)
								if (got.words[a] !== want.words[a])
									$display("  %s exp %h got %h", AXIS_NAME[a],
										want.words[a], got.words[a]);
						end
					end
				end
			end

			outstanding = offset_words_due.size();
		end
	end

endmodule

@@ bench/imu_offset_nulling_calibrator_core_test.sv @@
// Top of the calibrator bench: clock, reset, sample and register stimulus, result sink, verdict.
`timescale 1ns / 1ps
module imu_offset_nulling_calibrator_core_test
	import imuonc_pkg::*;
	import imuonc_bench_pkg::*;
;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 11;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int LONG_HOLD      = 200;   // result side stall, long enough to back up the input
	localparam int RAND_PHASES    = 7;
	localparam int PHASE_ITEMS    = 220;
	localparam int SETTLE_CYCLES  = 4;     // two-stage pipe plus margin

	// axis slots, gyro x/y/z then accel x/y/z
	localparam int GX = 0, GY = 1, GZ = 2, AX = 3, AY = 4, AZ = 5;

	localparam sample_t READ_MAX = 16'sh7FFF;
	localparam sample_t READ_MIN = 16'sh8000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write_en;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	sample_t     gyro_x, gyro_y, gyro_z;
	sample_t     accel_x, accel_y, accel_z;
	logic        out_valid;
	logic        out_stall;
	logic        write_valid;
	logic        done_res;
	word_t       gyro_word_x, gyro_word_y, gyro_word_z;
	word_t       accel_word_x, accel_word_y, accel_word_z;

	int          fail_count;
	int          outstanding;
	int          writes_seen;
	int          done_seen;

	// what the stimulus side believes the lock limits are, to steer readings
	limit_t      gyro_lim;
	limit_t      accel_lim;
	bit          send_quiet;
	bit          hold_output;
	int          samples_sent;

	always #(CLK_PERIOD / 2) clk = ~clk;

	imu_offset_nulling_calibrator_core dut (.*);

	imu_offset_nulling_calibrator_checker offset_chk (.*);

	// -------------------------------------------------------------------------
	// Stimulus helpers
	// -------------------------------------------------------------------------

	// One transaction on the sample channel. Optional gap first, then hold the
	// payload until the block takes it. Returns at the falling edge after accept.
	task automatic send_sample(input sample_t rd [NUM_AXES]);
		int gap;
		if ($urandom_range(0, 23) == 0)
			send_quiet = !send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		gyro_x  <= rd[GX];
		gyro_y  <= rd[GY];
		gyro_z  <= rd[GZ];
		accel_x <= rd[AX];
		accel_y <= rd[AY];
		accel_z <= rd[AZ];
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		samples_sent++;
	endtask

	// Stop offering and wait for every pending result to be taken.
	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(negedge clk);
	endtask

	// Full register load; only call with the block idle. Bit 15 of a limit
	// write is junk on purpose since the limit registers are 15 bits.
	task automatic load_settings(input word_t fo [NUM_AXES], input limit_t g_lim,
		input limit_t a_lim);
		write_reg(REG_FACTORY_GX, fo[GX]);
		write_reg(REG_FACTORY_GY, fo[GY]);
		write_reg(REG_FACTORY_GZ, fo[GZ]);
		write_reg(REG_FACTORY_AX, fo[AX]);
		write_reg(REG_FACTORY_AY, fo[AY]);
		write_reg(REG_FACTORY_AZ, fo[AZ]);
		write_reg(REG_GYRO_LIMIT, {($urandom_range(0, 1) != 0), g_lim});
		write_reg(REG_ACCEL_LIMIT, {($urandom_range(0, 1) != 0), a_lim});
		cfg_write_en <= 1'b0;
		gyro_lim  = g_lim;
		accel_lim = a_lim;
	endtask

	// Factory offsets lean toward the sign extremes so the sums wrap often.
	function automatic word_t pick_factory();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic limit_t pick_limit();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return limit_t'($urandom_range(1, 40));
			default: return limit_t'($urandom);
		endcase
	endfunction

	// A reading for one axis. stay_open forces the magnitude above the limit so
	// the axis keeps stepping; with a full-scale limit only the most negative
	// value qualifies. Otherwise mostly full range, sometimes near the limit.
	function automatic sample_t pick_reading(input limit_t lim, input bit stay_open);
		int      m;
		sample_t v;
		v = sample_t'($urandom);
		if (stay_open) begin
			if (((v < 0) ? -int'(v) : int'(v)) <= int'(lim)) begin
				if (lim == '1) begin
					v = READ_MIN;
				end else begin
					m = int'(lim) + 1 + $urandom_range(0, 32766 - int'(lim));
					v = ($urandom_range(0, 1) != 0) ? sample_t'(m) : sample_t'(-m);
				end
			end
		end else if ($urandom_range(0, 3) == 0) begin
			m = $urandom_range(0, (int'(lim) > 32765) ? 32767 : int'(lim) + 2);
			v = ($urandom_range(0, 1) != 0) ? sample_t'(m) : sample_t'(-m);
		end
		return v;
	endfunction

	task automatic run_phase(input int n_items, input logic [NUM_AXES-1:0] stay_open);
		sample_t rd [NUM_AXES];
		for (int k = 0; k < n_items; k++) begin
			for (int a = 0; a < NUM_AXES; a++)
				rd[a] = pick_reading((a < NUM_GYRO) ? gyro_lim : accel_lim, stay_open[a]);
			send_sample(rd);
		end
	endtask

	// -------------------------------------------------------------------------
	// Result sink: random stall per transaction, runs of no stall, and one long
	// hold on request so the input side backs up and stalls the sender.
	// -------------------------------------------------------------------------
	initial begin : result_sink
		int stall_len;
		bit quiet;
		out_stall = 1'b0;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 23) == 0)
				quiet = !quiet;
			stall_len = quiet ? 0 : $urandom_range(0, 9);
			if (hold_output) begin
				hold_output = 1'b0;
				stall_len = LONG_HOLD;
			end
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// -------------------------------------------------------------------------
	// Main sequence
	// -------------------------------------------------------------------------
	initial begin : stimulus
		word_t               fo [NUM_AXES];
		logic [NUM_AXES-1:0] open_axes;
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = REG_FACTORY_GX;
		cfg_data     = '0;
		in_valid     = 1'b0;
		gyro_x       = '0;
		gyro_y       = '0;
		gyro_z       = '0;
		accel_x      = '0;
		accel_y      = '0;
		accel_z      = '0;
		gyro_lim     = 15'd1;
		accel_lim    = 15'd1;
		send_quiet   = 1'b0;
		hold_output  = 1'b0;
		samples_sent = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: limits of one, factory offsets zero.
		// All-zero first sample is dropped; it would lock every axis otherwise.
		send_sample('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		// full-scale readings on most axes, small ones on accel x/y, every axis steps
		send_sample('{READ_MAX, READ_MIN, -READ_MAX, 16'sd2, -16'sd2, READ_MIN});
		// gyro z locks on zero without a step, accel x steps and locks at the limit
		send_sample('{READ_MIN, READ_MAX, 16'sd0, 16'sd1, -READ_MAX, 16'sd16384});
		// locked axes ignore large readings
		send_sample('{-16'sd3, 16'sd3, READ_MAX, READ_MIN, 16'sd5, -16'sd5});
		drain();

		// Factory offsets at the sign extremes so the sums wrap; limits of zero.
		fo = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000, 16'h8000, 16'h7FFF};
		load_settings(fo, '0, '0);
		send_sample('{-16'sd5, 16'sd5, 16'sd9, -16'sd9, 16'sd7, -16'sd7});
		send_sample('{-16'sd1, 16'sd1, 16'sd0, READ_MAX, -16'sd1, 16'sd1});
		send_sample('{READ_MIN, READ_MAX, READ_MIN, 16'sd0, READ_MAX, READ_MIN});
		drain();

		// Full-scale limits: the most negative reading still must not lock.
		fo = '{16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'hC000, 16'h3FFF};
		load_settings(fo, '1, '1);
		repeat (3)
			send_sample('{READ_MIN, READ_MIN, READ_MAX, 16'sd0, READ_MIN, READ_MIN});

		// Random phases. Gyro x and accel z never lock here so the block keeps
		// writing; gyro y may lock from the third phase, accel y from the fifth.
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain();
			foreach (fo[a])
				fo[a] = pick_factory();
			load_settings(fo, pick_limit(), pick_limit());
			if (p == 2)
				hold_output = 1'b1;
			open_axes = '0;
			open_axes[GX] = 1'b1;
			open_axes[AZ] = 1'b1;
			open_axes[GY] = (p < 2);
			open_axes[AY] = (p < 4);
			run_phase(PHASE_ITEMS, open_axes);
		end

		// Last phase: everything may lock. The all-zero sample finishes the
		// calibration if nothing did before; the rest land after completion.
		drain();
		foreach (fo[a])
			fo[a] = pick_factory();
		load_settings(fo, pick_limit(), pick_limit());
		run_phase(30, '0);
		send_sample('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		run_phase(12, '0);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Ran %0d samples under %0d register settings: %0d offset writes, %0d done results.",
			samples_sent, RAND_PHASES + 4, writes_seen, done_seen);
		$display("Included zero and full-scale limits, most negative readings, sum wrap and samples after completion.");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Timeout after %0d cycles", TIMEOUT_CYCLES);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/imuonc_pkg.sv
hw/rtl/imuonc_axis.sv
hw/rtl/imu_offset_nulling_calibrator_core.sv
bench/imu_offset_nulling_calibrator_checker.sv
bench/imu_offset_nulling_calibrator_core_test.sv
